// ===== hdl/bcdmux_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcdmux_pkg
// Shared constants, widths and the seven-segment decoder for the display
// driver.
// ----------------------------------------------------------------------------
package bcdmux_pkg;

  localparam int TIMER_W     = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int BYTE_W      = 8;
  localparam int BYTE_IDX_W  = 3;
  localparam int PHASE_W     = 2;
  localparam int DIGIT_W     = 4;

  // Display positions addressed by the scan: phase p and p plus four.
  localparam int SHOWN_POS   = 8;
  localparam int SHOWN_POS_W = 3;

  localparam int DIGITS_PER_ROW_DEF = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX       = 24'hFF_FFFF;
  localparam logic [TIMER_W-1:0] FAST_RESET      = 24'd10000;
  localparam logic [TIMER_W-1:0] SLOW_RESET      = 24'd199333;
  localparam logic [TIMER_W-1:0] REFRESH_RESET   = 24'd800;

  localparam logic [CFG_INDEX_W-1:0] CFG_FAST    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFRESH = 2'd2;

  localparam logic [BYTE_W-1:0] PHASE_MASK_BASE  = 8'h88;
  localparam logic [BYTE_W-1:0] SEG_BLANK        = 8'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE      = 4'd9;

  localparam logic [BYTE_IDX_W-1:0] IDX_MASK_A   = 3'd0;
  localparam logic [BYTE_IDX_W-1:0] IDX_MASK_B   = 3'd1;
  localparam logic [BYTE_IDX_W-1:0] IDX_LOWER_LO = 3'd2;
  localparam logic [BYTE_IDX_W-1:0] IDX_LOWER_HI = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] IDX_UPPER_LO = 3'd4;
  localparam logic [BYTE_IDX_W-1:0] IDX_UPPER_HI = 3'd5;

  // Segment pattern of one decimal digit, bit 0 is segment a.
  function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'b0011_1111;
      4'd1:    code = 8'b0000_0110;
      4'd2:    code = 8'b0101_1011;
      4'd3:    code = 8'b0100_1111;
      4'd4:    code = 8'b0110_0110;
      4'd5:    code = 8'b0110_1101;
      4'd6:    code = 8'b0111_1101;
      4'd7:    code = 8'b0000_0111;
      4'd8:    code = 8'b0111_1111;
      4'd9:    code = 8'b0110_1111;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bcd_counter_mux_display_driver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_counter_mux_display_driver
// Two decimal counters shown on a four-phase multiplexed seven-segment
// display through a chain of shift registers.
// ----------------------------------------------------------------------------
// Every input transfer is one microsecond tick (or an idle item when
// in_time_step is low). Three interval timers run off the ticks: the fast
// timer advances the lower row counter, the slow timer the upper row counter,
// and the refresh timer starts a display frame. A frame is six byte transfers
// on the out_ channel: the phase mask twice, then the segment codes of lower
// digits p and p+4 and upper digits p and p+4; byte five carries out_last_byte
// to request the latch pulse. Leading zeros are blanked. The block takes one
// tick per cycle: a tick passes through an input register and is worked out
// in the following cycle, while a frame drains from a separate frame buffer.
// A tick that would start a new frame waits in the input register only while
// the previous frame still has bytes to hand over other than its last, so a
// frame that is still draining, together with any cycles in which the
// receiver stalls it, is the only thing that can hold the input back. With a
// refresh on every tick and no output stalls the input therefore takes one
// tick per frame.
// Configuration writes on the cfg_ port take effect at once and should be
// made while the block is idle.
// ----------------------------------------------------------------------------
module bcd_counter_mux_display_driver #(
  parameter int DIGITS_PER_ROW = bcdmux_pkg::DIGITS_PER_ROW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [bcdmux_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bcdmux_pkg::TIMER_W-1:0]      cfg_wdata,
  // Tick input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_time_step,
  // Frame byte output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [bcdmux_pkg::BYTE_W-1:0]            out_shift_byte,
  output logic [bcdmux_pkg::BYTE_IDX_W-1:0]        out_byte_index,
  output logic                                     out_last_byte
);

  localparam int TW = bcdmux_pkg::TIMER_W;
  localparam int DW = bcdmux_pkg::DIGIT_W;
  localparam int BW = bcdmux_pkg::BYTE_W;

  // Configuration registers.
  logic [TW-1:0] fast_int_r, slow_int_r, refresh_int_r;

  // Input register.
  logic s1_valid_r;
  logic s1_step_r;

  // Counter and timer state.
  logic [DW-1:0] lower_r   [DIGITS_PER_ROW];
  logic [DW-1:0] upper_r   [DIGITS_PER_ROW];
  logic [DW-1:0] lower_nxt [DIGITS_PER_ROW];
  logic [DW-1:0] upper_nxt [DIGITS_PER_ROW];
  logic [bcdmux_pkg::PHASE_W-1:0] phase_r;
  logic [TW-1:0] fast_el_r, slow_el_r, refresh_el_r;
  logic [TW-1:0] fast_el_nxt, slow_el_nxt, refresh_el_nxt;
  logic [TW-1:0] fast_inc, slow_inc, refresh_inc;
  logic          fast_fire, slow_fire, refresh_fire;

  // Frame buffer and output sequencing.
  logic                                  frame_busy_r;
  logic [bcdmux_pkg::BYTE_IDX_W-1:0]     byte_idx_r;
  logic [BW-1:0]                         mask_r;
  logic [BW-1:0]                         lower_lo_r, lower_hi_r, upper_lo_r, upper_hi_r;

  // Segment codes of every shown position, after this tick's increments.
  logic [BW-1:0] lower_seg [bcdmux_pkg::SHOWN_POS];
  logic [BW-1:0] upper_seg [bcdmux_pkg::SHOWN_POS];
  logic [DIGITS_PER_ROW:0] lower_nz, upper_nz;

  logic tick;
  logic need_frame;
  logic frame_done;
  logic frame_free;
  logic stage_go;
  logic stage_tick;
  logic load_frame;

  // Saturating timers: a timer fires when its count reaches the interval.
  assign fast_inc    = (fast_el_r    != bcdmux_pkg::TIMER_MAX) ? fast_el_r + 1'b1    : fast_el_r;
  assign slow_inc    = (slow_el_r    != bcdmux_pkg::TIMER_MAX) ? slow_el_r + 1'b1    : slow_el_r;
  assign refresh_inc = (refresh_el_r != bcdmux_pkg::TIMER_MAX) ? refresh_el_r + 1'b1 : refresh_el_r;

  assign fast_fire    = fast_inc    >= fast_int_r;
  assign slow_fire    = slow_inc    >= slow_int_r;
  assign refresh_fire = refresh_inc >= refresh_int_r;

  assign fast_el_nxt    = fast_fire    ? '0 : fast_inc;
  assign slow_el_nxt    = slow_fire    ? '0 : slow_inc;
  assign refresh_el_nxt = refresh_fire ? '0 : refresh_inc;

  // Handshake between input register, frame buffer and output.
  assign tick       = s1_valid_r && s1_step_r;
  assign need_frame = tick && refresh_fire;
  assign frame_done = frame_busy_r && !out_stall
                      && (byte_idx_r == bcdmux_pkg::IDX_UPPER_HI);
  assign frame_free = !frame_busy_r || frame_done;
  assign stage_go   = !need_frame || frame_free;
  assign stage_tick = tick && stage_go;
  assign load_frame = need_frame && frame_free;
  assign in_stall   = s1_valid_r && !stage_go;

  // Decimal ripple increment of both rows.
  always_comb begin
    logic carry_lo;
    logic carry_up;
    carry_lo = fast_fire;
    carry_up = slow_fire;
    for (int i = 0; i < DIGITS_PER_ROW; i++) begin
      lower_nxt[i] = lower_r[i];
      upper_nxt[i] = upper_r[i];
      if (carry_lo) begin
        if (lower_r[i] >= bcdmux_pkg::DIGIT_NINE) begin
          lower_nxt[i] = '0;
        end else begin
          lower_nxt[i] = lower_r[i] + 1'b1;
          carry_lo     = 1'b0;
        end
      end
      if (carry_up) begin
        if (upper_r[i] >= bcdmux_pkg::DIGIT_NINE) begin
          upper_nxt[i] = '0;
        end else begin
          upper_nxt[i] = upper_r[i] + 1'b1;
          carry_up     = 1'b0;
        end
      end
    end
  end

  // A digit is lit when it or any more significant digit is non-zero.
  assign lower_nz[DIGITS_PER_ROW] = 1'b0;
  assign upper_nz[DIGITS_PER_ROW] = 1'b0;

  for (genvar k = 0; k < DIGITS_PER_ROW; k++) begin : g_nz
    assign lower_nz[k] = (lower_nxt[k] != '0) || lower_nz[k+1];
    assign upper_nz[k] = (upper_nxt[k] != '0) || upper_nz[k+1];
  end

  for (genvar k = 0; k < bcdmux_pkg::SHOWN_POS; k++) begin : g_seg
    if (k < DIGITS_PER_ROW) begin : g_digit
      assign lower_seg[k] = lower_nz[k] ? bcdmux_pkg::seg_code(lower_nxt[k])
                                        : bcdmux_pkg::SEG_BLANK;
      assign upper_seg[k] = upper_nz[k] ? bcdmux_pkg::seg_code(upper_nxt[k])
                                        : bcdmux_pkg::SEG_BLANK;
    end else begin : g_blank
      assign lower_seg[k] = bcdmux_pkg::SEG_BLANK;
      assign upper_seg[k] = bcdmux_pkg::SEG_BLANK;
    end
  end

  // Configuration registers; the unused index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_int_r    <= bcdmux_pkg::FAST_RESET;
      slow_int_r    <= bcdmux_pkg::SLOW_RESET;
      refresh_int_r <= bcdmux_pkg::REFRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcdmux_pkg::CFG_FAST:    fast_int_r    <= cfg_wdata;
        bcdmux_pkg::CFG_SLOW:    slow_int_r    <= cfg_wdata;
        bcdmux_pkg::CFG_REFRESH: refresh_int_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register, counters, timers and scan phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_step_r    <= 1'b0;
      phase_r      <= '0;
      fast_el_r    <= '0;
      slow_el_r    <= '0;
      refresh_el_r <= '0;
      for (int i = 0; i < DIGITS_PER_ROW; i++) begin
        lower_r[i] <= '0;
        upper_r[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        s1_step_r  <= in_time_step;
      end
      if (stage_tick) begin
        fast_el_r    <= fast_el_nxt;
        slow_el_r    <= slow_el_nxt;
        refresh_el_r <= refresh_el_nxt;
        for (int i = 0; i < DIGITS_PER_ROW; i++) begin
          lower_r[i] <= lower_nxt[i];
          upper_r[i] <= upper_nxt[i];
        end
      end
      if (load_frame) begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  // Frame buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_busy_r <= 1'b0;
      byte_idx_r   <= bcdmux_pkg::IDX_MASK_A;
    end else if (load_frame) begin
      frame_busy_r <= 1'b1;
      byte_idx_r   <= bcdmux_pkg::IDX_MASK_A;
    end else if (frame_done) begin
      frame_busy_r <= 1'b0;
      byte_idx_r   <= bcdmux_pkg::IDX_MASK_A;
    end else if (frame_busy_r && !out_stall) begin
      byte_idx_r   <= byte_idx_r + 1'b1;
    end
  end

  // Frame payload.
  always_ff @(posedge clk) begin
    if (load_frame) begin
      mask_r     <= bcdmux_pkg::PHASE_MASK_BASE >> phase_r;
      lower_lo_r <= lower_seg[{1'b0, phase_r}];
      lower_hi_r <= lower_seg[{1'b1, phase_r}];
      upper_lo_r <= upper_seg[{1'b0, phase_r}];
      upper_hi_r <= upper_seg[{1'b1, phase_r}];
    end
  end

  // Output byte selection from the frame buffer.
  always_comb begin
    unique case (byte_idx_r)
      bcdmux_pkg::IDX_MASK_A:   out_shift_byte = mask_r;
      bcdmux_pkg::IDX_MASK_B:   out_shift_byte = mask_r;
      bcdmux_pkg::IDX_LOWER_LO: out_shift_byte = lower_lo_r;
      bcdmux_pkg::IDX_LOWER_HI: out_shift_byte = lower_hi_r;
      bcdmux_pkg::IDX_UPPER_LO: out_shift_byte = upper_lo_r;
      bcdmux_pkg::IDX_UPPER_HI: out_shift_byte = upper_hi_r;
      default:                  out_shift_byte = bcdmux_pkg::SEG_BLANK;
    endcase
  end

  assign out_valid      = frame_busy_r;
  assign out_byte_index = byte_idx_r;
  assign out_last_byte  = (byte_idx_r == bcdmux_pkg::IDX_UPPER_HI);

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
// Ticks and idle items are offered on the in_ channel with random gaps. Every
// accepted tick is fed to a behavioural copy of the three interval timers, the
// two decimal rows and the scan phase, which queues the six frame bytes that
// the block must produce. Each transfer on the out_ channel is compared, field
// by field, with the oldest queued byte. Interval registers are rewritten only
// while the block is quiet, and the run covers the reset intervals, zero and
// full-scale intervals, an unused register index, intervals lowered below the
// elapsed count, a long output hold-off and a random phase over many settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ROW_DIGITS    = bcdmux_pkg::DIGITS_PER_ROW_DEF;
  localparam int ROW_W         = ROW_DIGITS * bcdmux_pkg::DIGIT_W;
  localparam int HALF_SCAN     = bcdmux_pkg::SHOWN_POS / 2;
  localparam int FRAME_BYTES   = 6;
  // Cycles a tick may still be in flight inside the block after the last
  // expected byte has been seen.
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_OFF_LEN  = 150;
  localparam int RESET_TICKS   = 100;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_ITEMS   = 36;

  // The index port is two bits wide, so one index names no register at all.
  localparam logic [bcdmux_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [bcdmux_pkg::BYTE_W-1:0]     shift_byte;
    logic [bcdmux_pkg::BYTE_IDX_W-1:0] byte_index;
    logic                              last_byte;
  } frame_byte_t;

  // Clock, reset and DUT connections. Every input has a known value from
  // time zero.
  logic                               clk          = 1'b0;
  logic                               rst_n        = 1'b0;
  logic                               cfg_we       = 1'b0;
  logic [bcdmux_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [bcdmux_pkg::TIMER_W-1:0]     cfg_wdata    = '0;
  logic                               in_valid     = 1'b0;
  logic                               in_time_step = 1'b0;
  logic                               out_stall    = 1'b0;
  logic                               in_stall;
  logic                               out_valid;
  logic [bcdmux_pkg::BYTE_W-1:0]      out_shift_byte;
  logic [bcdmux_pkg::BYTE_IDX_W-1:0]  out_byte_index;
  logic                               out_last_byte;

  // Shared control of the traffic shape.
  bit idling_enabled  = 1'b1;
  int hold_off_cycles = 0;
  int failure_count   = 0;
  int cycle_count     = 0;

  // Behavioural state of the display: interval settings, elapsed counts,
  // both decimal rows (digit 0 in the low nibble) and the scan phase.
  logic [bcdmux_pkg::TIMER_W-1:0] fast_period, slow_period, refresh_period;
  logic [bcdmux_pkg::TIMER_W-1:0] fast_count, slow_count, refresh_count;
  logic [ROW_W-1:0]               lower_row, upper_row;
  logic [bcdmux_pkg::PHASE_W-1:0] scan_phase;

  frame_byte_t pending_frame_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bcd_counter_mux_display_driver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_time_step   (in_time_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shift_byte (out_shift_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte)
  );

  // --------------------------------------------------------------------------
  // Display behaviour
  // --------------------------------------------------------------------------

  function automatic logic [bcdmux_pkg::BYTE_W-1:0] digit_segments(
      input logic [bcdmux_pkg::DIGIT_W-1:0] digit);
    case (digit)
      4'd0:    return 8'h3F;
      4'd1:    return 8'h06;
      4'd2:    return 8'h5B;
      4'd3:    return 8'h4F;
      4'd4:    return 8'h66;
      4'd5:    return 8'h6D;
      4'd6:    return 8'h7D;
      4'd7:    return 8'h07;
      4'd8:    return 8'h7F;
      4'd9:    return 8'h6F;
      default: return bcdmux_pkg::SEG_BLANK;
    endcase
  endfunction

  // One tick of an interval timer: the top bit says it fired, the rest is
  // the new elapsed count. The count saturates rather than wrapping, and a
  // count already at or past the interval fires at once.
  function automatic logic [bcdmux_pkg::TIMER_W:0] timer_advance(
      input logic [bcdmux_pkg::TIMER_W-1:0] elapsed,
      input logic [bcdmux_pkg::TIMER_W-1:0] period);
    logic [bcdmux_pkg::TIMER_W-1:0] next_count;
    next_count = (elapsed == bcdmux_pkg::TIMER_MAX) ? elapsed : elapsed + 1'b1;
    if (next_count >= period) return {1'b1, {bcdmux_pkg::TIMER_W{1'b0}}};
    return {1'b0, next_count};
  endfunction

  // Decimal increment with carry ripple; all nines wrap to zero.
  function automatic logic [ROW_W-1:0] bcd_increment(input logic [ROW_W-1:0] row);
    for (int i = 0; i < ROW_DIGITS; i++) begin
      if (row[i*bcdmux_pkg::DIGIT_W +: bcdmux_pkg::DIGIT_W] >= bcdmux_pkg::DIGIT_NINE) begin
        row[i*bcdmux_pkg::DIGIT_W +: bcdmux_pkg::DIGIT_W] = '0;
      end else begin
        row[i*bcdmux_pkg::DIGIT_W +: bcdmux_pkg::DIGIT_W] =
            row[i*bcdmux_pkg::DIGIT_W +: bcdmux_pkg::DIGIT_W] + 1'b1;
        return row;
      end
    end
    return row;
  endfunction

  // A digit is blanked when it and every more significant digit are zero,
  // which also blanks a row holding zero. Positions past the row are blank.
  function automatic logic [bcdmux_pkg::BYTE_W-1:0] shown_segments(
      input logic [ROW_W-1:0] row, input int pos);
    logic [ROW_W-1:0] leading_part;
    if (pos >= ROW_DIGITS) return bcdmux_pkg::SEG_BLANK;
    leading_part = row >> (pos * bcdmux_pkg::DIGIT_W);
    if (leading_part == '0) return bcdmux_pkg::SEG_BLANK;
    return digit_segments(row[pos*bcdmux_pkg::DIGIT_W +: bcdmux_pkg::DIGIT_W]);
  endfunction

  function automatic void reset_display_state();
    fast_period    = bcdmux_pkg::FAST_RESET;
    slow_period    = bcdmux_pkg::SLOW_RESET;
    refresh_period = bcdmux_pkg::REFRESH_RESET;
    fast_count     = '0;
    slow_count     = '0;
    refresh_count  = '0;
    lower_row      = '0;
    upper_row      = '0;
    scan_phase     = '0;
    pending_frame_bytes.delete();
  endfunction

  // Advances the display by one accepted item and queues the frame bytes it
  // causes. The counters move before the refresh of the same tick, so a frame
  // already shows the incremented rows.
  function automatic void advance_display(input logic time_step);
    logic [bcdmux_pkg::TIMER_W:0]  fast_t, slow_t, refresh_t;
    logic [bcdmux_pkg::BYTE_W-1:0] frame [FRAME_BYTES];
    frame_byte_t                   fb;
    int                            p;
    if (!time_step) return;
    fast_t        = timer_advance(fast_count, fast_period);
    refresh_t     = timer_advance(refresh_count, refresh_period);
    slow_t        = timer_advance(slow_count, slow_period);
    fast_count    = fast_t[bcdmux_pkg::TIMER_W-1:0];
    refresh_count = refresh_t[bcdmux_pkg::TIMER_W-1:0];
    slow_count    = slow_t[bcdmux_pkg::TIMER_W-1:0];
    if (fast_t[bcdmux_pkg::TIMER_W]) lower_row = bcd_increment(lower_row);
    if (slow_t[bcdmux_pkg::TIMER_W]) upper_row = bcd_increment(upper_row);
    if (!refresh_t[bcdmux_pkg::TIMER_W]) return;

    p        = int'(scan_phase);
    frame[0] = bcdmux_pkg::PHASE_MASK_BASE >> p;
    frame[1] = frame[0];
    frame[2] = shown_segments(lower_row, p);
    frame[3] = shown_segments(lower_row, p + HALF_SCAN);
    frame[4] = shown_segments(upper_row, p);
    frame[5] = shown_segments(upper_row, p + HALF_SCAN);
    scan_phase = scan_phase + 1'b1;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      fb.shift_byte = frame[k];
      fb.byte_index = bcdmux_pkg::BYTE_IDX_W'(k);
      fb.last_byte  = (k == FRAME_BYTES - 1);
      pending_frame_bytes.push_back(fb);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------

  function automatic void log_failure(input string msg);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endfunction

  // Both monitors run at the rising edge and so see the values from just
  // before it, the same values the block itself registers.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) advance_display(in_time_step);
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        log_failure($sformatf("unexpected frame byte %02h index %0d last %0b",
                              out_shift_byte, out_byte_index, out_last_byte));
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_shift_byte !== want.shift_byte || out_byte_index !== want.byte_index ||
            out_last_byte !== want.last_byte) begin
          log_failure($sformatf({"frame byte mismatch: got %02h index %0d last %0b, ",
                                 "expected %02h index %0d last %0b"},
                                out_shift_byte, out_byte_index, out_last_byte,
                                want.shift_byte, want.byte_index, want.last_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame bytes outstanding", cycle_count,
               pending_frame_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Traffic
  // --------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver drives out_stall at the falling edge. A requested hold-off
  // is counted down here and overrides the random pattern; with idling
  // switched off and no hold-off pending it never stalls at all.
  initial begin
    int  stall_run;
    int  free_run;
    logic stall_next;
    stall_run = 0;
    free_run  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        stall_next = 1'b1;
      end else if (!idling_enabled) begin
        stall_next = 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        stall_next = 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        stall_next = 1'b0;
      end else begin
        stall_run  = pick_gap();
        free_run   = $urandom_range(1, 8);
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Offers one item and returns at the falling edge after its transfer. Valid
  // is only lowered for a gap, so a following item keeps it high without a
  // second assignment in the same step.
  task automatic send_item(input logic time_step);
    int gap;
    gap = idling_enabled ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_time_step <= time_step;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every queued byte has been seen, then lets the last ticks
  // leave the block's pipeline before anything is reconfigured.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bcdmux_pkg::CFG_INDEX_W-1:0] index,
                           input logic [bcdmux_pkg::TIMER_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    case (index)
      bcdmux_pkg::CFG_FAST:    fast_period    = value;
      bcdmux_pkg::CFG_SLOW:    slow_period    = value;
      bcdmux_pkg::CFG_REFRESH: refresh_period = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_intervals(input logic [bcdmux_pkg::TIMER_W-1:0] fast,
                                 input logic [bcdmux_pkg::TIMER_W-1:0] slow,
                                 input logic [bcdmux_pkg::TIMER_W-1:0] refresh);
    write_reg(bcdmux_pkg::CFG_FAST, fast);
    write_reg(bcdmux_pkg::CFG_SLOW, slow);
    write_reg(bcdmux_pkg::CFG_REFRESH, refresh);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Untouched registers: no timer may fire within the first hundred ticks,
  // so the block stays silent and both rows stay at zero.
  task automatic test_reset_intervals();
    repeat (RESET_TICKS) send_item(1'b1);
    drain_pipeline();
  endtask

  // Idle items sit between ticks and must change nothing.
  task automatic test_idle_items();
    logic [5:0] pattern;
    pattern = 6'b101101;
    write_intervals(24'd1, 24'd3, 24'd2);
    for (int i = 0; i < 6; i++) send_item(pattern[i]);
    drain_pipeline();
  endtask

  // An interval of zero fires on every tick, so each tick brings a frame.
  task automatic test_zero_interval();
    write_intervals('0, '0, '0);
    repeat (4) send_item(1'b1);
    drain_pipeline();
  endtask

  // A write to the unused index must leave every interval as it was; a stray
  // write into the refresh interval would show up as extra frames.
  task automatic test_unused_index();
    write_reg(bcdmux_pkg::CFG_REFRESH, 24'd4);
    write_reg(CFG_UNUSED, 24'd1);
    repeat (4) send_item(1'b1);
    drain_pipeline();
  endtask

  // Intervals lowered beneath the elapsed counts fire on the very next tick.
  task automatic test_lowered_interval();
    write_intervals(24'd40, 24'd40, 24'd40);
    repeat (6) send_item(1'b1);
    drain_pipeline();
    write_intervals(24'd3, 24'd5, 24'd3);
    repeat (4) send_item(1'b1);
    drain_pipeline();
  endtask

  task automatic test_full_scale_interval();
    write_intervals(bcdmux_pkg::TIMER_MAX, bcdmux_pkg::TIMER_MAX, bcdmux_pkg::TIMER_MAX);
    repeat (3) send_item(1'b1);
    drain_pipeline();
  endtask

  // Every tick starts a frame while the receiver holds off for a long
  // stretch, so the frame buffer fills and the input has to stall.
  task automatic test_output_hold_off();
    write_intervals(24'd1, 24'd2, 24'd1);
    idling_enabled  = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (30) send_item(1'b1);
    drain_pipeline();
    idling_enabled = 1'b1;
  endtask

  // Rounds of mostly ticks with some idle items, each under its own set of
  // intervals. Short intervals keep frames frequent and the rows moving.
  task automatic test_random_traffic();
    logic [bcdmux_pkg::TIMER_W-1:0] fast, slow, refresh;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      if (round == 0) begin
        fast    = 24'd1;
        slow    = 24'd1;
        refresh = 24'd1;
      end else if (round == 1) begin
        fast    = 24'd1;
        slow    = bcdmux_pkg::TIMER_MAX;
        refresh = 24'd2;
      end else begin
        fast    = bcdmux_pkg::TIMER_W'($urandom_range(0, 4));
        slow    = bcdmux_pkg::TIMER_W'($urandom_range(0, 12));
        refresh = ($urandom_range(0, 3) == 0) ? bcdmux_pkg::TIMER_W'($urandom_range(11, 40))
                                              : bcdmux_pkg::TIMER_W'($urandom_range(0, 10));
      end
      write_intervals(fast, slow, refresh);
      idling_enabled = (round % 3 != 2);
      repeat (ROUND_ITEMS) send_item($urandom_range(0, 99) < 85);
      drain_pipeline();
    end
    idling_enabled = 1'b1;
  endtask

  initial begin
    reset_display_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_intervals();
    test_idle_items();
    test_zero_interval();
    test_unused_index();
    test_lowered_interval();
    test_full_scale_interval();
    test_output_hold_off();
    test_random_traffic();

    if (failure_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
